// ----- hdl/acp_pkg.sv -----
// ----------------------------------------------------------------------------
// acp_pkg
// shared types, opcodes, packet classes and the identifier table
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam int unsigned HEADER_BYTES = 18;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] OP_POLL = 16'h2000;
    localparam logic [15:0] OP_SYNC = 16'h5200;
    localparam logic [15:0] OP_DMX  = 16'h5000;

    localparam logic [9:0] MAX_DMX_LEN = 10'd512;

    localparam logic [2:0] CLS_NOT_ARTNET  = 3'd0;
    localparam logic [2:0] CLS_POLL        = 3'd1;
    localparam logic [2:0] CLS_SYNC        = 3'd2;
    localparam logic [2:0] CLS_DMX_OK      = 3'd3;
    localparam logic [2:0] CLS_WRONG_UNIV  = 3'd4;
    localparam logic [2:0] CLS_DMX_SHORT   = 3'd5;
    localparam logic [2:0] CLS_OTHER_OP    = 3'd6;

    localparam logic KIND_SLOT    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic        result_kind;
        logic [8:0]  slot_index;
        logic [7:0]  slot_value;
        logic [2:0]  packet_class;
        logic [7:0]  sequence_number;
        logic [9:0]  dmx_length;
        logic [31:0] packet_total;
        logic [31:0] dmx_total;
        logic [31:0] poll_total;
        logic [31:0] sync_total;
        logic [31:0] wrong_universe_total;
        logic        last_of_run;
    } t_result;

    typedef struct packed {
        logic slot_vld;
        logic sum_vld;
    } t_push;

    function automatic logic [7:0] ident_byte(input logic [2:0] idx);
        logic [7:0] r;
        case (idx)
            3'd0:    r = 8'h41;
            3'd1:    r = 8'h72;
            3'd2:    r = 8'h74;
            3'd3:    r = 8'h2D;
            3'd4:    r = 8'h4E;
            3'd5:    r = 8'h65;
            3'd6:    r = 8'h74;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/acp_parser.sv -----
// ----------------------------------------------------------------------------
// acp_parser
// per-byte header capture, slot forwarding and end-of-packet classification
// ----------------------------------------------------------------------------
module acp_parser #(
    parameter int unsigned MAX_SLOTS = 512
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_of_packet,
    input  logic [14:0]        i_listen_universe,
    output acp_pkg::t_push     o_push,
    output acp_pkg::t_result   o_slot,
    output acp_pkg::t_result   o_summary
);
    import acp_pkg::*;

    localparam logic [9:0]  SLOT_LIM = 10'(MAX_SLOTS);
    localparam logic [9:0]  HDR10    = 10'(HEADER_BYTES);
    localparam logic [10:0] HDR11    = 11'(HEADER_BYTES);

    logic [9:0]  r_byte_pos;
    logic        r_header_good;
    logic [15:0] r_opcode;
    logic [14:0] r_universe;
    logic [9:0]  r_decl_len;
    logic [7:0]  r_pend_seq;
    logic [7:0]  r_acc_seq;
    logic [31:0] r_pkt_cnt;
    logic [31:0] r_dmx_cnt;
    logic [31:0] r_poll_cnt;
    logic [31:0] r_sync_cnt;
    logic [31:0] r_wrong_cnt;

    logic        n_header_good;
    logic [15:0] n_opcode;
    logic [14:0] n_universe;
    logic [9:0]  n_decl_len;
    logic [7:0]  n_pend_seq;
    logic [7:0]  n_acc_seq;
    logic [31:0] n_pkt_cnt;
    logic [31:0] n_dmx_cnt;
    logic [31:0] n_poll_cnt;
    logic [31:0] n_sync_cnt;
    logic [31:0] n_wrong_cnt;

    logic [10:0] len_sum;
    logic [9:0]  limit;
    logic        for_us;
    logic [9:0]  slot_off;
    logic        slot_vld;
    logic [10:0] pkt_len;
    logic [10:0] present;
    logic [10:0] delivered;
    logic [2:0]  cls;

    // header capture
    always_comb begin
        n_header_good = r_header_good;
        n_opcode      = r_opcode;
        n_universe    = r_universe;
        n_decl_len    = r_decl_len;
        n_pend_seq    = r_pend_seq;
        len_sum       = {1'b0, r_decl_len} + {3'b0, i_data_byte};
        if (r_byte_pos < 10'd8) begin
            if (i_data_byte != ident_byte(r_byte_pos[2:0])) begin
                n_header_good = 1'b0;
            end
        end else begin
            case (r_byte_pos)
                10'd8:  n_opcode = {8'h00, i_data_byte};
                10'd9:  n_opcode = r_opcode | {i_data_byte, 8'h00};
                10'd12: n_pend_seq = i_data_byte;
                10'd14: n_universe = {7'b0, i_data_byte};
                10'd15: n_universe = r_universe | {i_data_byte[6:0], 8'h00};
                10'd16: begin
                    if (i_data_byte >= 8'd2) begin
                        n_decl_len = MAX_DMX_LEN;
                    end else begin
                        n_decl_len = {1'b0, i_data_byte[0], 8'h00};
                    end
                end
                10'd17: begin
                    if (r_decl_len < MAX_DMX_LEN) begin
                        if (len_sum > {1'b0, MAX_DMX_LEN}) begin
                            n_decl_len = MAX_DMX_LEN;
                        end else begin
                            n_decl_len = len_sum[9:0];
                        end
                    end
                end
                default: n_opcode = r_opcode;
            endcase
        end
    end

    // slot forwarding
    always_comb begin
        limit    = (n_decl_len > SLOT_LIM) ? SLOT_LIM : n_decl_len;
        for_us   = n_header_good && (n_opcode == OP_DMX) && (n_universe == i_listen_universe);
        slot_off = r_byte_pos - HDR10;
        slot_vld = i_accept && (r_byte_pos >= HDR10) && for_us && (slot_off < limit);
    end

    // end-of-packet classification
    always_comb begin
        pkt_len     = {1'b0, r_byte_pos} + 11'd1;
        present     = pkt_len - HDR11;
        cls         = CLS_NOT_ARTNET;
        delivered   = '0;
        n_acc_seq   = r_acc_seq;
        n_pkt_cnt   = r_pkt_cnt + 32'd1;
        n_dmx_cnt   = r_dmx_cnt;
        n_poll_cnt  = r_poll_cnt;
        n_sync_cnt  = r_sync_cnt;
        n_wrong_cnt = r_wrong_cnt;
        if ((pkt_len >= 11'd10) && n_header_good) begin
            if (n_opcode == OP_POLL) begin
                cls        = CLS_POLL;
                n_poll_cnt = r_poll_cnt + 32'd1;
            end else if (n_opcode == OP_SYNC) begin
                cls        = CLS_SYNC;
                n_sync_cnt = r_sync_cnt + 32'd1;
            end else if (n_opcode != OP_DMX) begin
                cls = CLS_OTHER_OP;
            end else if (pkt_len < HDR11) begin
                cls = CLS_DMX_SHORT;
            end else if (n_universe != i_listen_universe) begin
                cls         = CLS_WRONG_UNIV;
                n_wrong_cnt = r_wrong_cnt + 32'd1;
            end else begin
                cls       = CLS_DMX_OK;
                delivered = ({1'b0, limit} < present) ? {1'b0, limit} : present;
                n_acc_seq = n_pend_seq;
                n_dmx_cnt = r_dmx_cnt + 32'd1;
            end
        end
    end

    always_comb begin
        o_push.slot_vld = slot_vld;
        o_push.sum_vld  = i_accept && i_end_of_packet;

        o_slot                 = '0;
        o_slot.result_kind     = KIND_SLOT;
        o_slot.slot_index      = slot_off[8:0];
        o_slot.slot_value      = i_data_byte;
        o_slot.last_of_run     = !i_end_of_packet;

        o_summary                      = '0;
        o_summary.result_kind          = KIND_SUMMARY;
        o_summary.packet_class         = cls;
        o_summary.sequence_number      = n_acc_seq;
        o_summary.dmx_length           = delivered[9:0];
        o_summary.packet_total         = n_pkt_cnt;
        o_summary.dmx_total            = n_dmx_cnt;
        o_summary.poll_total           = n_poll_cnt;
        o_summary.sync_total           = n_sync_cnt;
        o_summary.wrong_universe_total = n_wrong_cnt;
        o_summary.last_of_run          = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_pos    <= '0;
            r_header_good <= 1'b1;
            r_opcode      <= '0;
            r_universe    <= '0;
            r_decl_len    <= '0;
            r_pend_seq    <= '0;
            r_acc_seq     <= '0;
            r_pkt_cnt     <= '0;
            r_dmx_cnt     <= '0;
            r_poll_cnt    <= '0;
            r_sync_cnt    <= '0;
            r_wrong_cnt   <= '0;
        end else if (i_accept) begin
            if (i_end_of_packet) begin
                r_byte_pos    <= '0;
                r_header_good <= 1'b1;
                r_opcode      <= '0;
                r_universe    <= '0;
                r_decl_len    <= '0;
                r_pend_seq    <= '0;
                r_acc_seq     <= n_acc_seq;
                r_pkt_cnt     <= n_pkt_cnt;
                r_dmx_cnt     <= n_dmx_cnt;
                r_poll_cnt    <= n_poll_cnt;
                r_sync_cnt    <= n_sync_cnt;
                r_wrong_cnt   <= n_wrong_cnt;
            end else begin
                if (r_byte_pos != 10'h3FF) begin
                    r_byte_pos <= r_byte_pos + 10'd1;
                end
                r_header_good <= n_header_good;
                r_opcode      <= n_opcode;
                r_universe    <= n_universe;
                r_decl_len    <= n_decl_len;
                r_pend_seq    <= n_pend_seq;
            end
        end
    end

endmodule

// ----- hdl/acp_out_queue.sv -----
// ----------------------------------------------------------------------------
// acp_out_queue
// small result queue, takes up to two records per beat, gives one per beat
// ----------------------------------------------------------------------------
module acp_out_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  acp_pkg::t_push     i_push,
    input  acp_pkg::t_result   i_first,
    input  acp_pkg::t_result   i_second,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_stall,
    output acp_pkg::t_result   o_result
);
    import acp_pkg::*;

    localparam logic [QUEUE_AW:0] DEPTH_M2 = (QUEUE_AW + 1)'(QUEUE_DEPTH - 2);

    t_result             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    logic                pop;
    logic [QUEUE_AW:0]   push_n;
    logic [QUEUE_AW-1:0] second_ptr;

    always_comb begin
        pop        = (r_count != '0) && !i_stall;
        push_n     = (QUEUE_AW + 1)'(i_push.slot_vld) + (QUEUE_AW + 1)'(i_push.sum_vld);
        second_ptr = i_push.slot_vld ? r_wr_ptr + 1'b1 : r_wr_ptr;
        o_full     = r_count > DEPTH_M2;
        o_valid    = r_count != '0;
        o_result   = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push.slot_vld) begin
            r_mem[r_wr_ptr] <= i_first;
        end
        if (i_push.sum_vld) begin
            r_mem[second_ptr] <= i_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + push_n[QUEUE_AW-1:0];
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + push_n - (QUEUE_AW + 1)'(pop);
        end
    end

endmodule

// ----- hdl/artnet_packet_classifier_core.sv -----
// ----------------------------------------------------------------------------
// artnet_packet_classifier_core
// byte-serial art-net receiver: header check, dmx slot forwarding, packet
// summary with wrapping statistics counters
//
//   channel   dir   handshake                 beat
//   in        in    i_in_valid / o_in_stall   one payload byte + end flag
//   out       out   o_out_valid / i_out_stall one slot byte or one summary
//   cfg       in    i_cfg_wr_en               listen universe, 15 bit
//
// one byte per cycle while o_in_stall is low; a result enters the result queue the cycle after its byte
// a packet-end byte that also carries a slot gives two beats on the out side
// the 4-entry result queue stalls input when fewer than two entries are free
// synchronous active-low reset clears parser state, counters and the queue
// ----------------------------------------------------------------------------
module artnet_packet_classifier_core #(
    parameter int unsigned MAX_SLOTS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [14:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_packet,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [8:0]  o_slot_index,
    output logic [7:0]  o_slot_value,
    output logic [2:0]  o_packet_class,
    output logic [7:0]  o_sequence_number,
    output logic [9:0]  o_dmx_length,
    output logic [31:0] o_packet_total,
    output logic [31:0] o_dmx_total,
    output logic [31:0] o_poll_total,
    output logic [31:0] o_sync_total,
    output logic [31:0] o_wrong_universe_total,
    output logic        o_last_of_run
);
    import acp_pkg::*;

    logic [14:0] r_listen_universe;
    logic        in_accept;
    logic        q_full;
    t_push       push;
    t_result     slot_rec;
    t_result     sum_rec;
    t_result     out_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_universe <= '0;
        end else if (i_cfg_wr_en) begin
            r_listen_universe <= i_cfg_wr_data;
        end
    end

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    acp_parser #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_parser (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (in_accept),
        .i_data_byte       (i_data_byte),
        .i_end_of_packet   (i_end_of_packet),
        .i_listen_universe (r_listen_universe),
        .o_push            (push),
        .o_slot            (slot_rec),
        .o_summary         (sum_rec)
    );

    acp_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_first  (slot_rec),
        .i_second (sum_rec),
        .o_full   (q_full),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_result (out_rec)
    );

    assign o_result_kind          = out_rec.result_kind;
    assign o_slot_index           = out_rec.slot_index;
    assign o_slot_value           = out_rec.slot_value;
    assign o_packet_class         = out_rec.packet_class;
    assign o_sequence_number      = out_rec.sequence_number;
    assign o_dmx_length           = out_rec.dmx_length;
    assign o_packet_total         = out_rec.packet_total;
    assign o_dmx_total            = out_rec.dmx_total;
    assign o_poll_total           = out_rec.poll_total;
    assign o_sync_total           = out_rec.sync_total;
    assign o_wrong_universe_total = out_rec.wrong_universe_total;
    assign o_last_of_run          = out_rec.last_of_run;

`ifndef NO_ASSERTIONS
    a_slot_fields_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_SLOT) |->
        (o_packet_class == CLS_NOT_ARTNET && o_dmx_length == 10'd0 &&
         o_packet_total == 32'd0))
        else $error("slot beat carries summary fields");

    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_SUMMARY) |->
        (o_last_of_run && o_slot_index == 9'd0 && o_slot_value == 8'd0))
        else $error("summary beat malformed");

    a_length_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == KIND_SUMMARY && o_dmx_length != 10'd0) |->
        (o_packet_class == CLS_DMX_OK && o_dmx_length <= 10'(MAX_SLOTS)))
        else $error("dmx length on non-accepted packet or above limit");

    a_eop_gives_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_end_of_packet) |=> o_out_valid)
        else $error("packet end produced no result");
`endif

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for artnet_packet_classifier_core: hand-made packets,
// then random art-net traffic with idling on both sides, every slot and
// summary beat compared field by field against a scoreboard
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import acp_pkg::*;

    localparam logic [63:0] ART_ID      = 64'h4172_742D_4E65_7400;
    localparam int          QUIET_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 400;

    class artnet_result_predictor;
        logic [14:0] listen_universe;
        logic [9:0]  position;
        bit          ident_ok;
        logic [15:0] opcode;
        logic [14:0] universe;
        logic [9:0]  declared_len;
        logic [7:0]  seq_pending;
        logic [7:0]  seq_accepted;
        logic [31:0] packets;
        logic [31:0] dmx_packets;
        logic [31:0] polls;
        logic [31:0] syncs;
        logic [31:0] wrong_universes;
        t_result     expected_results[$];
        int          errors;

        function new();
            listen_universe = '0;
            seq_accepted    = '0;
            packets         = '0;
            dmx_packets     = '0;
            polls           = '0;
            syncs           = '0;
            wrong_universes = '0;
            errors          = 0;
            clear_packet();
        endfunction

        function void clear_packet();
            position     = '0;
            ident_ok     = 1'b1;
            opcode       = '0;
            universe     = '0;
            declared_len = '0;
            seq_pending  = '0;
        endfunction

        function void note_byte(logic [7:0] b, logic eop);
            logic [9:0]  p;
            logic [9:0]  lim;
            logic [10:0] n;
            logic [10:0] present;
            logic [9:0]  delivered;
            logic [2:0]  cls;
            int          sum;
            bit          for_us;
            t_result     r;
            p = position;
            if (p < 10'd8) begin
                if (b != ART_ID[8 * (7 - p) +: 8])
                    ident_ok = 1'b0;
            end else begin
                case (p)
                    10'd8: opcode = {8'h00, b};
                    10'd9: opcode[15:8] = b;
                    10'd12: seq_pending = b;
                    10'd14: universe = {7'd0, b};
                    10'd15: universe[14:8] = b[6:0];
                    10'd16: declared_len = (b >= 8'd2) ? 10'd512 : {b[1:0], 8'h00};
                    10'd17: begin
                        if (declared_len < 10'd512) begin
                            sum = declared_len + b;
                            declared_len = (sum > 512) ? 10'd512 : 10'(sum);
                        end
                    end
                    default: ;
                endcase
            end
            lim = (declared_len > 10'd512) ? 10'd512 : declared_len;
            for_us = ident_ok && opcode == OP_DMX && universe == listen_universe;
            if (p >= HEADER_BYTES && for_us && p - HEADER_BYTES < lim) begin
                r = '0;
                r.result_kind = KIND_SLOT;
                r.slot_index  = 9'(p - HEADER_BYTES);
                r.slot_value  = b;
                r.last_of_run = !eop;
                expected_results.push_back(r);
            end
            if (!eop) begin
                if (position != 10'd1023)
                    position++;
                return;
            end
            n = {1'b0, p} + 11'd1;
            cls = CLS_NOT_ARTNET;
            delivered = '0;
            packets++;
            if (n >= 11'd10 && ident_ok) begin
                if (opcode == OP_POLL) begin
                    polls++;
                    cls = CLS_POLL;
                end else if (opcode == OP_SYNC) begin
                    syncs++;
                    cls = CLS_SYNC;
                end else if (opcode != OP_DMX) begin
                    cls = CLS_OTHER_OP;
                end else if (n < HEADER_BYTES) begin
                    cls = CLS_DMX_SHORT;
                end else if (universe != listen_universe) begin
                    wrong_universes++;
                    cls = CLS_WRONG_UNIV;
                end else begin
                    present = n - 11'(HEADER_BYTES);
                    delivered = ({1'b0, lim} < present) ? lim : 10'(present);
                    seq_accepted = seq_pending;
                    dmx_packets++;
                    cls = CLS_DMX_OK;
                end
            end
            r = '0;
            r.result_kind          = KIND_SUMMARY;
            r.packet_class         = cls;
            r.sequence_number      = seq_accepted;
            r.dmx_length           = delivered;
            r.packet_total         = packets;
            r.dmx_total            = dmx_packets;
            r.poll_total           = polls;
            r.sync_total           = syncs;
            r.wrong_universe_total = wrong_universes;
            r.last_of_run          = 1'b1;
            expected_results.push_back(r);
            clear_packet();
        endfunction

        function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_results.size() == 0) begin
                $error("result beat with no expected result");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            cmp_field("result_kind", want.result_kind, got.result_kind);
            cmp_field("slot_index", want.slot_index, got.slot_index);
            cmp_field("slot_value", want.slot_value, got.slot_value);
            cmp_field("packet_class", want.packet_class, got.packet_class);
            cmp_field("sequence_number", want.sequence_number, got.sequence_number);
            cmp_field("dmx_length", want.dmx_length, got.dmx_length);
            cmp_field("packet_total", want.packet_total, got.packet_total);
            cmp_field("dmx_total", want.dmx_total, got.dmx_total);
            cmp_field("poll_total", want.poll_total, got.poll_total);
            cmp_field("sync_total", want.sync_total, got.sync_total);
            cmp_field("wrong_universe_total", want.wrong_universe_total,
                      got.wrong_universe_total);
            cmp_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_wr_en     = 1'b0;
    logic [14:0] i_cfg_wr_data   = '0;
    logic        i_in_valid      = 1'b0;
    logic [7:0]  i_data_byte     = '0;
    logic        i_end_of_packet = 1'b0;
    logic        i_out_stall     = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_result_kind;
    logic [8:0]  o_slot_index;
    logic [7:0]  o_slot_value;
    logic [2:0]  o_packet_class;
    logic [7:0]  o_sequence_number;
    logic [9:0]  o_dmx_length;
    logic [31:0] o_packet_total;
    logic [31:0] o_dmx_total;
    logic [31:0] o_poll_total;
    logic [31:0] o_sync_total;
    logic [31:0] o_wrong_universe_total;
    logic        o_last_of_run;

    t_result     result_seen;
    logic [7:0]  pkt_bytes[$];
    int          send_idle_pct  = 30;
    int          recv_stall_pct = 64;
    bit          hold_req       = 1'b0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;

    artnet_result_predictor predictor = new();

    assign result_seen = {o_result_kind, o_slot_index, o_slot_value, o_packet_class,
                          o_sequence_number, o_dmx_length, o_packet_total, o_dmx_total,
                          o_poll_total, o_sync_total, o_wrong_universe_total,
                          o_last_of_run};

    artnet_packet_classifier_core dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_wr_en            (i_cfg_wr_en),
        .i_cfg_wr_data          (i_cfg_wr_data),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_data_byte            (i_data_byte),
        .i_end_of_packet        (i_end_of_packet),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_result_kind          (o_result_kind),
        .o_slot_index           (o_slot_index),
        .o_slot_value           (o_slot_value),
        .o_packet_class         (o_packet_class),
        .o_sequence_number      (o_sequence_number),
        .o_dmx_length           (o_dmx_length),
        .o_packet_total         (o_packet_total),
        .o_dmx_total            (o_dmx_total),
        .o_poll_total           (o_poll_total),
        .o_sync_total           (o_sync_total),
        .o_wrong_universe_total (o_wrong_universe_total),
        .o_last_of_run          (o_last_of_run)
    );

    always #5 i_clk = ~i_clk;

    // receiver side: random stall, or a long hold-off when asked
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            predictor.check_result(result_seen);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_byte(logic [7:0] b, logic eop);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid      = 1'b1;
        i_data_byte     = b;
        i_end_of_packet = eop;
        do @(posedge i_clk); while (o_in_stall);
        predictor.note_byte(b, eop);
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
    endtask

    function automatic void make_header(logic [15:0] op, logic [14:0] univ,
                                        logic [15:0] len);
        pkt_bytes.delete();
        for (int i = 0; i < 8; i++)
            pkt_bytes.push_back(ART_ID[8 * (7 - i) +: 8]);
        pkt_bytes.push_back(op[7:0]);
        pkt_bytes.push_back(op[15:8]);
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(univ[7:0]);
        pkt_bytes.push_back({1'($urandom), univ[14:8]});
        pkt_bytes.push_back(len[15:8]);
        pkt_bytes.push_back(len[7:0]);
    endfunction

    function automatic void fit_length(int n);
        while (pkt_bytes.size() > n)
            void'(pkt_bytes.pop_back());
        while (pkt_bytes.size() < n)
            pkt_bytes.push_back(8'($urandom));
    endfunction

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (predictor.pending() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_universe(logic [14:0] u);
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = u;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        predictor.listen_universe = u;
    endtask

    task automatic send_random(int budget);
        int          sent;
        int          k;
        int          j;
        int          n;
        logic [15:0] op;
        logic [15:0] len;
        logic [14:0] univ;
        sent = 0;
        while (sent < budget) begin
            k    = $urandom_range(99);
            j    = $urandom_range(9);
            n    = $urandom_range(18, 34);
            op   = OP_DMX;
            univ = predictor.listen_universe;
            if (j < 5)
                len = 16'($urandom_range(0, 14));
            else if (j < 7)
                len = {8'($urandom_range(2, 255)), 8'($urandom)};
            else if (j < 8)
                len = {8'h01, 8'($urandom)};
            else
                len = {8'h00, 8'($urandom)};
            if (k >= 35 && k < 50) begin
                univ = univ ^ 15'($urandom_range(1, 32767));
            end else if (k >= 50 && k < 58) begin
                op = OP_POLL;
                n  = $urandom_range(10, 24);
            end else if (k >= 58 && k < 66) begin
                op = OP_SYNC;
                n  = $urandom_range(10, 24);
            end else if (k >= 66 && k < 74) begin
                op = 16'($urandom);
                if (op == OP_POLL || op == OP_SYNC || op == OP_DMX)
                    op = op ^ 16'h0001;
                n = $urandom_range(10, 24);
            end else if (k >= 74 && k < 82) begin
                n = $urandom_range(1, 17);
            end
            make_header(op, univ, len);
            if (k >= 82 && k < 90)
                pkt_bytes[$urandom_range(0, 7)] ^= 8'($urandom_range(1, 255));
            if (k >= 90) begin
                pkt_bytes.delete();
                n = $urandom_range(1, 30);
            end
            fit_length(n);
            send_packet();
            sent += n;
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        write_universe(15'h0000);
        pkt_bytes = '{8'hFF};
        send_packet();
        make_header(OP_POLL, 15'h0000, 16'h0000);
        fit_length(9);
        send_packet();
        make_header(OP_POLL, 15'h0000, 16'h0000);
        fit_length(10);
        send_packet();
        make_header(OP_SYNC, 15'h0000, 16'h0000);
        fit_length(10);
        send_packet();
        make_header(16'h5001, 15'h0000, 16'h0000);
        fit_length(10);
        send_packet();
        make_header(OP_DMX, 15'h0000, 16'h0004);
        fit_length(17);
        send_packet();
        make_header(OP_DMX, 15'h0000, 16'h0000);
        fit_length(18);
        send_packet();
        make_header(OP_DMX, 15'h0000, 16'h0203);
        fit_length(21);
        send_packet();
        make_header(OP_DMX, 15'h7FFF, 16'h0004);
        fit_length(18);
        send_packet();
        make_header(OP_DMX, 15'h0000, 16'h0001);
        fit_length(20);
        send_packet();
        make_header(OP_DMX, 15'h0000, 16'h0008);
        pkt_bytes[3] = 8'h2E;
        fit_length(22);
        send_packet();
        drain();

        write_universe(15'h7FFF);
        send_random(50);
        drain();

        send_idle_pct  = 64;
        recv_stall_pct = 30;
        write_universe(15'($urandom));
        send_random(50);
        drain();

        // no idling; long hold-off on the result side while a long packet streams in
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_universe(15'($urandom));
        hold_req = 1'b1;
        make_header(OP_DMX, predictor.listen_universe, 16'h0200);
        fit_length(1030);
        send_packet();
        send_random(30);
        drain();

        if (predictor.errors == 0 && predictor.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
